// ----- design/deq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int Q_DEPTH  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CUR_RESET  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CUR_PREV   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CUR_NEXT   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_READ_CUR   = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                wr;
        logic                rd;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_op_ctl;

endpackage

`default_nettype wire

// ----- design/deq_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module deq_front
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [VAL_W-1:0]      i_push_value,
    input  wire logic                  i_q_ready,
    output logic                       o_q_push,
    output t_op_ctl                    o_ctl,
    output logic [AW-1:0]              o_addr,
    output logic [DATA_WIDTH-1:0]      o_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_count, n_count;

    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] tail, last, head_prev, head_next, cur_prev, cur_next;
    logic [DATA_WIDTH+VAL_W-1:0] data_wide;
    logic [CW+COUNT_W-1:0]       count_wide;
    logic [STATUS_W-1:0]         status;
    logic                        wr, rd;

    assign o_ready  = i_q_ready;
    assign o_q_push = i_valid && i_q_ready;

    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign last_sum  = tail_sum - SW'(1);
    assign tail      = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign last      = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
    assign head_prev = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_next = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign cur_prev  = (r_cursor == '0) ? AW'(DEPTH - 1) : r_cursor - AW'(1);
    assign cur_next  = (r_cursor == AW'(DEPTH - 1)) ? '0 : r_cursor + AW'(1);

    assign data_wide = {{DATA_WIDTH{1'b0}}, i_push_value};
    assign o_data    = data_wide[DATA_WIDTH-1:0];

    always_comb begin
        n_head   = r_head;
        n_cursor = r_cursor;
        n_count  = r_count;
        status   = ST_OK;
        wr       = 1'b0;
        rd       = 1'b0;
        o_addr   = r_cursor;
        case (i_command)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (r_count == CW'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    wr = 1'b1;
                    if (i_command == CMD_PUSH_BACK) begin
                        o_addr = tail;
                    end else begin
                        o_addr = head_prev;
                        n_head = head_prev;
                    end
                    if (r_count == '0) begin
                        n_cursor = o_addr;
                    end
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    rd = 1'b1;
                    if (i_command == CMD_POP_BACK) begin
                        o_addr = last;
                    end else begin
                        o_addr = r_head;
                        n_head = head_next;
                    end
                    n_count = r_count - CW'(1);
                    if (r_cursor == o_addr || r_count == CW'(1)) begin
                        n_cursor = n_head;
                    end
                end
            end
            CMD_CUR_RESET: begin
                n_cursor = r_head;
            end
            CMD_CUR_PREV: begin
                if (r_count > CW'(1)) begin
                    n_cursor = (r_cursor == r_head) ? last : cur_prev;
                end
            end
            CMD_CUR_NEXT: begin
                if (r_count > CW'(1)) begin
                    n_cursor = (r_cursor == last) ? r_head : cur_next;
                end
            end
            default: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    rd = 1'b1;
                end
            end
        endcase
    end

    assign count_wide = {{COUNT_W{1'b0}}, n_count};

    always_comb begin
        o_ctl.wr     = wr;
        o_ctl.rd     = rd;
        o_ctl.status = status;
        o_ctl.count  = count_wide[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_cursor <= '0;
            r_count  <= '0;
        end else if (o_q_push) begin
            r_head   <= n_head;
            r_cursor <= n_cursor;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- design/deq_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module deq_queue
    import deq_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int NW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [Q_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_fill;

    assign o_ready = (r_fill != NW'(Q_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + NW'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/deq_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module deq_back
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    output logic                       o_q_pop,
    input  wire t_op_ctl               i_ctl,
    input  wire logic [AW-1:0]         i_addr,
    input  wire logic [DATA_WIDTH-1:0] i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [VAL_W-1:0]           o_read_value,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_W-1:0]         o_entry_count
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_valid;
    t_op_ctl               r_ctl;
    logic                  advance;
    logic [DATA_WIDTH+VAL_W-1:0] rd_wide;

    assign advance = !r_valid || i_ready;
    assign o_q_pop = advance && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_ctl.wr) begin
            r_mem[i_addr] <= i_data;
        end
        if (o_q_pop && i_ctl.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
        if (o_q_pop) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_q_valid;
        end
    end

    assign rd_wide       = {{VAL_W{1'b0}}, r_rd_data};
    assign o_valid       = r_valid;
    assign o_read_value  = r_ctl.rd ? rd_wide[VAL_W-1:0] : '0;
    assign o_status      = r_ctl.status;
    assign o_entry_count = r_ctl.count;

endmodule

`default_nettype wire

// ----- design/double_ended_queue_with_cursor.sv -----
// Channel   Handshake            Word
// command   i_valid / o_ready    i_command, i_push_value
// result    o_valid / i_ready    o_read_value, o_status, o_entry_count
//
// One command is accepted per clock while the two-entry queue has room.
// A result passes through the queue and then the registered read of the entry store;
// throughput is one word per clock while the result side is not stalled.
// Reset clears the pointers, the count, the queue fill and the result valid flag;
// the entry store, queue slots and result data are not. A stalled result holds the
// back end, and the front end keeps accepting until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_with_cursor
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [VAL_W-1:0]    i_push_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [VAL_W-1:0]         o_read_value,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COUNT_W-1:0]       o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OPW = $bits(t_op_ctl) + AW + DATA_WIDTH;

    logic                  q_ready, q_push, q_valid, q_pop;
    t_op_ctl               f_ctl, b_ctl;
    logic [AW-1:0]         f_addr, b_addr;
    logic [DATA_WIDTH-1:0] f_data, b_data;
    logic [OPW-1:0]        q_out;

    deq_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .i_q_ready    (q_ready),
        .o_q_push     (q_push),
        .o_ctl        (f_ctl),
        .o_addr       (f_addr),
        .o_data       (f_data)
    );

    deq_queue #(
        .WIDTH (OPW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_ctl, f_addr, f_data}),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_ctl, b_addr, b_data} = q_out;

    deq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_ctl         (b_ctl),
        .i_addr        (b_addr),
        .i_data        (b_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

// ----- design/deq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire logic [CMD_W-1:0]    i_command,
    input wire logic [VAL_W-1:0]    i_push_value,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire logic [VAL_W-1:0]    o_read_value,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [COUNT_W-1:0]  o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW+COUNT_W-1:0] FULL_WIDE = (CW + COUNT_W)'(DEPTH);
    localparam logic [COUNT_W-1:0] FULL_COUNT = FULL_WIDE[COUNT_W-1:0];

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_command) && $stable(i_push_value))
        else $error("command word changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_read_value) && $stable(o_status)
                                && $stable(o_entry_count))
        else $error("result word changed while stalled");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_read_value == '0 && o_entry_count == '0)
        else $error("empty status with data or entries");

    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_read_value == '0
                                           && o_entry_count == FULL_COUNT)
        else $error("full status with data or wrong count");

endmodule

bind double_ended_queue_with_cursor deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_command     (i_command),
    .i_push_value  (i_push_value),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_read_value  (o_read_value),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int PLAN_ROWS    = 20;
    localparam int RANDOM_WORDS = 2000;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PEND_DEPTH   = 8;
    localparam int PEND_W       = $clog2(PEND_DEPTH);

    localparam logic [CMD_W-1:0] ALL_CMDS [8] = '{
        CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_POP_BACK, CMD_POP_FRONT,
        CMD_CUR_RESET, CMD_CUR_PREV, CMD_CUR_NEXT, CMD_READ_CUR
    };

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_deque_result;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
        logic [4:0]       reps;
        logic             known;
        t_deque_result    typed;
    } t_plan_row;

    typedef enum {GROW, SHRINK, MIXED} t_traffic_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [CMD_W-1:0]    i_command;
    logic [VAL_W-1:0]    i_push_value;
    logic                o_valid;
    logic                i_ready;
    logic [VAL_W-1:0]    o_read_value;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_entry_count;

    logic [VAL_W-1:0]   shadow_store [DEPTH];
    logic [PTR_W-1:0]   shadow_head;
    logic [PTR_W-1:0]   shadow_cursor;
    logic [COUNT_W-1:0] shadow_count;

    t_deque_result pend_ring [PEND_DEPTH];
    logic [PEND_W-1:0] pend_wr_ptr;
    logic [PEND_W-1:0] pend_rd_ptr;
    int            pend_count;
    t_plan_row     directed_plan [PLAN_ROWS];
    logic          typed_known;
    t_deque_result typed_result;
    int            burst_left;
    int            error_count;
    int            idle_cycles;

    double_ended_queue_with_cursor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_deque_result deque_apply(input logic [CMD_W-1:0] cmd,
                                                  input logic [VAL_W-1:0] data);
        t_deque_result    r;
        logic [PTR_W-1:0] pos;
        logic [PTR_W-1:0] last;
        r = '0;
        r.status = ST_OK;
        last = shadow_head + shadow_count[PTR_W-1:0] - 1'b1;
        case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (shadow_count == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (cmd == CMD_PUSH_BACK) begin
                        pos = shadow_head + shadow_count[PTR_W-1:0];
                    end else begin
                        shadow_head = shadow_head - 1'b1;
                        pos = shadow_head;
                    end
                    shadow_store[pos] = data;
                    if (shadow_count == 0) begin
                        shadow_cursor = pos;
                    end
                    shadow_count = shadow_count + 1'b1;
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = (cmd == CMD_POP_BACK) ? last : shadow_head;
                    r.value = shadow_store[pos];
                    if (cmd == CMD_POP_FRONT) begin
                        shadow_head = shadow_head + 1'b1;
                    end
                    shadow_count = shadow_count - 1'b1;
                    if (shadow_cursor == pos || shadow_count == 0) begin
                        shadow_cursor = shadow_head;
                    end
                end
            end
            CMD_CUR_RESET: begin
                shadow_cursor = shadow_head;
            end
            CMD_CUR_PREV: begin
                if (shadow_count > 1) begin
                    shadow_cursor = (shadow_cursor == shadow_head) ? last
                                                                   : shadow_cursor - 1'b1;
                end
            end
            CMD_CUR_NEXT: begin
                if (shadow_count > 1) begin
                    shadow_cursor = (shadow_cursor == last) ? shadow_head
                                                            : shadow_cursor + 1'b1;
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = shadow_store[shadow_cursor];
                end
            end
        endcase
        r.count = shadow_count;
        return r;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input t_traffic_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            GROW: begin
                if (r < 55) return ALL_CMDS[$urandom_range(0, 1)];
                if (r < 70) return ALL_CMDS[$urandom_range(2, 3)];
                return ALL_CMDS[$urandom_range(4, 7)];
            end
            SHRINK: begin
                if (r < 15) return ALL_CMDS[$urandom_range(0, 1)];
                if (r < 65) return ALL_CMDS[$urandom_range(2, 3)];
                return ALL_CMDS[$urandom_range(4, 7)];
            end
            default: return ALL_CMDS[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                             input logic known, input t_deque_result typed);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_push_value <= val;
        typed_known  <= known;
        typed_result <= typed;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pend_count != 0) @(posedge i_clk);
    endtask

    initial begin : receiver
        int phase_left;
        int style;
        int tick;
        phase_left = 0;
        style = 0;
        tick = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                style = $urandom_range(0, 3);
                phase_left = $urandom_range(16, 64);
            end
            phase_left--;
            tick++;
            case (style)
                0: i_ready <= 1'b1;
                1: i_ready <= $urandom_range(0, 1);
                2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= tick[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_deque_result want;
        t_deque_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = deque_apply(i_command, i_push_value);
                if (typed_known) begin
                    want = typed_result;
                end
                if (pend_count == PEND_DEPTH) begin
                    $error("more result words outstanding than expected");
                    error_count++;
                end else begin
                    pend_ring[pend_wr_ptr] = want;
                    pend_wr_ptr = pend_wr_ptr + 1'b1;
                    pend_count++;
                end
            end
            if (o_valid && i_ready) begin
                got = '{o_read_value, o_status, o_entry_count};
                if (pend_count == 0) begin
                    $error("result word arrived with none pending");
                    error_count++;
                end else begin
                    want = pend_ring[pend_rd_ptr];
                    pend_rd_ptr = pend_rd_ptr + 1'b1;
                    pend_count--;
                    if (got.value !== want.value) begin
                        $error("read_value expected %h got %h", want.value, got.value);
                        error_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count expected %0d got %0d", want.count, got.count);
                        error_count++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_traffic_mode mode;
        int            mode_left;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_command    = CMD_CUR_RESET;
        i_push_value = '0;
        typed_known  = 1'b0;
        typed_result = '0;
        burst_left   = 0;
        error_count  = 0;
        idle_cycles  = 0;
        pend_wr_ptr  = '0;
        pend_rd_ptr  = '0;
        pend_count   = 0;
        shadow_head   = '0;
        shadow_cursor = '0;
        shadow_count  = '0;
        mode = MIXED;
        mode_left = 0;
        directed_plan = '{
            '{CMD_POP_BACK,   32'h0,         5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
            '{CMD_POP_FRONT,  32'h0,         5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
            '{CMD_READ_CUR,   32'h0,         5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
            '{CMD_CUR_NEXT,   32'h0,         5'd1,  1'b1, '{32'h0, ST_OK, 5'd0}},
            '{CMD_CUR_PREV,   32'h0,         5'd1,  1'b1, '{32'h0, ST_OK, 5'd0}},
            '{CMD_CUR_RESET,  32'h0,         5'd1,  1'b1, '{32'h0, ST_OK, 5'd0}},
            '{CMD_PUSH_BACK,  32'hFFFFFFFF,  5'd1,  1'b1, '{32'h0, ST_OK, 5'd1}},
            '{CMD_CUR_NEXT,   32'h0,         5'd1,  1'b0, '0},
            '{CMD_READ_CUR,   32'h0,         5'd1,  1'b1, '{32'hFFFFFFFF, ST_OK, 5'd1}},
            '{CMD_PUSH_FRONT, 32'h0,         5'd1,  1'b0, '0},
            '{CMD_CUR_PREV,   32'h0,         5'd1,  1'b0, '0},
            '{CMD_READ_CUR,   32'h0,         5'd1,  1'b0, '0},
            '{CMD_POP_FRONT,  32'h0,         5'd1,  1'b0, '0},
            '{CMD_CUR_NEXT,   32'h0,         5'd1,  1'b0, '0},
            '{CMD_PUSH_BACK,  32'h80000001,  5'd14, 1'b0, '0},
            '{CMD_PUSH_FRONT, 32'h7FFFFFFE,  5'd1,  1'b1, '{32'h0, ST_OK, 5'd16}},
            '{CMD_PUSH_BACK,  32'h12345678,  5'd1,  1'b1, '{32'h0, ST_FULL, 5'd16}},
            '{CMD_PUSH_FRONT, 32'h9ABCDEF0,  5'd1,  1'b1, '{32'h0, ST_FULL, 5'd16}},
            '{CMD_POP_BACK,   32'h0,         5'd1,  1'b0, '0},
            '{CMD_POP_FRONT,  32'h0,         5'd1,  1'b0, '0}
        };
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            for (int k = 0; k < directed_plan[r].reps; k++) begin
                send_word(directed_plan[r].cmd, directed_plan[r].value + k,
                          directed_plan[r].known, directed_plan[r].typed);
            end
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0: mode = GROW;
                    1: mode = SHRINK;
                    default: mode = MIXED;
                endcase
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (n == RANDOM_WORDS / 2) begin
                wait_drained();
            end
            send_word(pick_command(mode), pick_value(), 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pend_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/deq_pkg.sv
design/deq_front.sv
design/deq_queue.sv
design/deq_back.sv
design/double_ended_queue_with_cursor.sv
design/deq_checker.sv
sim/tb.sv
